// File: sv/psieve_pkg.sv
// Shared types and constants for the prime sieve table.
// Request/result payloads, microword layout, step addresses and status flags.
// No dependencies.
package psieve_pkg;

  localparam logic OP_BUILD = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [15:0] bound;
    logic [12:0] index;
  } req_t;

  typedef struct packed {
    logic [15:0] value;
    logic        valid_res;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_BINIT,
    S_CLEAR,
    S_NTWO,
    S_OTEST,
    S_OCHECK,
    S_MARK,
    S_ONEXT,
    S_GINIT,
    S_GREAD,
    S_GCHECK,
    S_DONE
  } step_t;

  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_DISPATCH,
    C_SMALL,
    C_CLR_MORE,
    C_SQ_GT,
    C_COMPOSITE,
    C_MARK_MORE,
    C_N_GT
  } cond_t;

  typedef enum logic [1:0] {
    N_HOLD,
    N_ZERO,
    N_TWO,
    N_INC
  } nop_t;

  typedef enum logic [1:0] {
    M_HOLD,
    M_SQ,
    M_ADD
  } mop_t;

  typedef struct packed {
    cond_t cond;
    step_t target;
    nop_t  n_op;
    mop_t  m_op;
    logic  map_we;
    logic  mark;
    logic  cnt_clr;
    logic  gather;
    logic  out_en;
    logic  out_build;
  } uword_t;

  localparam uword_t UW_NOP = '{
    cond: C_NONE, target: S_IDLE, n_op: N_HOLD, m_op: M_HOLD,
    map_we: 1'b0, mark: 1'b0, cnt_clr: 1'b0, gather: 1'b0,
    out_en: 1'b0, out_build: 1'b0
  };

  typedef struct packed {
    logic below_two;
    logic clr_more;
    logic sq_gt;
    logic composite;
    logic mark_more;
    logic n_gt;
  } stat_t;

endpackage

// File: sv/psieve_useq.sv
// Microcode sequencer for the prime sieve table: step counter, control ROM
// and jump logic. Depends on psieve_pkg.
module psieve_useq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              operation,
  input  psieve_pkg::stat_t stat,
  output psieve_pkg::uword_t ctl,
  output logic              busy,
  output logic              accept
);
  import psieve_pkg::*;

  step_t upc;
  step_t upc_next;
  logic  taken;

  function automatic uword_t rom(step_t s);
    uword_t w;
    w = UW_NOP;
    unique case (s)
      S_IDLE: begin
        w.cond = C_DISPATCH;
      end
      S_READ: begin
        w.out_en = 1'b1;
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
      S_BINIT: begin
        w.cnt_clr = 1'b1;
        w.n_op    = N_ZERO;
        w.cond    = C_SMALL;
        w.target  = S_DONE;
      end
      S_CLEAR: begin
        w.map_we = 1'b1;
        w.n_op   = N_INC;
        w.cond   = C_CLR_MORE;
        w.target = S_CLEAR;
      end
      S_NTWO: begin
        w.n_op = N_TWO;
      end
      S_OTEST: begin
        w.cond   = C_SQ_GT;
        w.target = S_GINIT;
      end
      S_OCHECK: begin
        w.m_op   = M_SQ;
        w.cond   = C_COMPOSITE;
        w.target = S_ONEXT;
      end
      S_MARK: begin
        w.map_we = 1'b1;
        w.mark   = 1'b1;
        w.m_op   = M_ADD;
        w.cond   = C_MARK_MORE;
        w.target = S_MARK;
      end
      S_ONEXT: begin
        w.n_op   = N_INC;
        w.cond   = C_ALWAYS;
        w.target = S_OTEST;
      end
      S_GINIT: begin
        w.n_op = N_TWO;
      end
      S_GREAD: begin
        w.cond   = C_N_GT;
        w.target = S_DONE;
      end
      S_GCHECK: begin
        w.gather = 1'b1;
        w.n_op   = N_INC;
        w.cond   = C_ALWAYS;
        w.target = S_GREAD;
      end
      S_DONE: begin
        w.out_en    = 1'b1;
        w.out_build = 1'b1;
        w.cond      = C_ALWAYS;
        w.target    = S_IDLE;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

  always_comb begin
    ctl    = rom(upc);
    busy   = (upc != S_IDLE);
    accept = start & ~busy;
  end

  always_comb begin
    unique case (ctl.cond)
      C_ALWAYS:    taken = 1'b1;
      C_SMALL:     taken = stat.below_two;
      C_CLR_MORE:  taken = stat.clr_more;
      C_SQ_GT:     taken = stat.sq_gt;
      C_COMPOSITE: taken = stat.composite;
      C_MARK_MORE: taken = stat.mark_more;
      C_N_GT:      taken = stat.n_gt;
      default:     taken = 1'b0;
    endcase
    if (ctl.cond == C_DISPATCH) begin
      if (!start) begin
        upc_next = S_IDLE;
      end else if (operation == OP_READ) begin
        upc_next = S_READ;
      end else begin
        upc_next = S_BINIT;
      end
    end else if (taken) begin
      upc_next = ctl.target;
    end else begin
      upc_next = step_t'(upc + 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= S_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// File: sv/psieve_dp.sv
// Datapath of the prime sieve table: counters, composite bitmap, prime list
// and result register, driven by the microword. Depends on psieve_pkg.
module psieve_dp #(
  parameter int MAX_BOUND  = 65535,
  parameter int LIST_DEPTH = 8192
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  psieve_pkg::req_t   req,
  input  psieve_pkg::uword_t ctl,
  output psieve_pkg::stat_t  stat,
  output psieve_pkg::res_t   res,
  output logic               done
);
  import psieve_pkg::*;

  localparam int EFF = (MAX_BOUND < 65535) ? MAX_BOUND : 65535;
  localparam int NW  = $clog2(EFF + 1);
  localparam int SQW = 2 * NW + 2;
  localparam int CW  = $clog2(LIST_DEPTH + 1);
  localparam int AW  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

  logic [NW-1:0]  bnd;
  logic [12:0]    idx;
  logic [NW:0]    n;
  logic [NW:0]    m;
  logic [SQW-1:0] sq;
  logic [CW-1:0]  cnt;

  logic           map_mem [0:EFF];
  logic           map_q;
  logic [15:0]    list_mem [0:LIST_DEPTH-1];
  logic [15:0]    list_q;

  logic [NW-1:0]  map_addr;
  logic           map_data;
  logic           room;
  logic           rd_ok;
  logic [NW+1:0]  m_sum;

  always_comb begin
    map_addr = ctl.mark ? m[NW-1:0] : n[NW-1:0];
    map_data = ctl.mark ? 1'b1 : (n < (NW+1)'(2));
    room     = (32'(cnt) < LIST_DEPTH);
    rd_ok    = (32'(idx) < 32'(cnt)) && (32'(idx) < LIST_DEPTH);
    m_sum    = (NW+2)'(m) + (NW+2)'(n);

    stat.below_two = (bnd < NW'(2));
    stat.clr_more  = (n != (NW+1)'(bnd));
    stat.sq_gt     = (sq > SQW'(bnd));
    stat.composite = map_q;
    stat.mark_more = (m_sum <= (NW+2)'(bnd));
    stat.n_gt      = (n > (NW+1)'(bnd));
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx <= req.index;
      if (req.bound > 16'(EFF)) begin
        bnd <= NW'(EFF);
      end else begin
        bnd <= NW'(req.bound);
      end
    end
    case (ctl.n_op)
      N_ZERO: begin
        n  <= '0;
        sq <= '0;
      end
      N_TWO: begin
        n  <= (NW+1)'(2);
        sq <= SQW'(4);
      end
      N_INC: begin
        n  <= n + (NW+1)'(1);
        sq <= sq + SQW'({n, 1'b1});
      end
      default: ;
    endcase
    case (ctl.m_op)
      M_SQ:    m <= (NW+1)'(sq);
      M_ADD:   m <= m + n;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.map_we) begin
      map_mem[map_addr] <= map_data;
    end
    map_q <= map_mem[n[NW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (ctl.gather && !map_q && room) begin
      list_mem[cnt[AW-1:0]] <= 16'(n);
    end
    list_q <= list_mem[AW'(req.index)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctl.cnt_clr) begin
      cnt <= '0;
    end else if (ctl.gather && !map_q && room) begin
      cnt <= cnt + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl.out_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_en) begin
      if (ctl.out_build) begin
        res.value     <= 16'(cnt);
        res.valid_res <= 1'b1;
      end else begin
        res.value     <= rd_ok ? list_q : 16'd0;
        res.valid_res <= rd_ok;
      end
    end
  end

`ifndef SYNTHESIS
  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results in adjacent cycles");

  a_mark_in_bound: assert property (@(posedge clk) disable iff (rst)
    (ctl.map_we && ctl.mark) |-> (m <= (NW+1)'(bnd)))
    else $error("mark beyond bound");

  a_cnt_limit: assert property (@(posedge clk) disable iff (rst)
    32'(cnt) <= LIST_DEPTH)
    else $error("prime count past list depth");

  a_gather_room: assert property (@(posedge clk) disable iff (rst)
    (ctl.gather && !map_q && !room) |=> $stable(cnt))
    else $error("count moved on a full list");
`endif

endmodule

// File: sv/prime_sieve_table.sv
// Top level of the prime sieve table: sequencer plus datapath.
// Depends on psieve_pkg, psieve_useq and psieve_dp.
//
// An item is taken when start is high and busy is low; its one result shows
// on res for a single cycle with done high, and must be captured then. A
// read of the prime list passes through S_READ and returns to idle, and a
// new item is taken only once the sequencer is back in idle. A build clears
// the bitmap in a sweep that walks one entry a cycle up to the bound, then
// runs the marking passes, then a gather pass that reads and checks each
// number in turn. A bound below 2 goes from BINIT straight to DONE. Bounds
// above MAX_BOUND saturate; once LIST_DEPTH primes are stored the count
// stops growing. No clearing pass after reset: reads before the first build
// return valid_res 0.
module prime_sieve_table #(
  parameter int MAX_BOUND  = 65535,
  parameter int LIST_DEPTH = 8192
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  psieve_pkg::req_t req,
  output logic             done,
  output psieve_pkg::res_t res
);
  import psieve_pkg::*;

  uword_t ctl;
  stat_t  stat;
  logic   accept;

  psieve_useq u_useq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .operation (req.operation),
    .stat      (stat),
    .ctl       (ctl),
    .busy      (busy),
    .accept    (accept)
  );

  psieve_dp #(
    .MAX_BOUND  (MAX_BOUND),
    .LIST_DEPTH (LIST_DEPTH)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req),
    .ctl    (ctl),
    .stat   (stat),
    .res    (res),
    .done   (done)
  );

endmodule
